// ===== src/dsdft_pkg.sv =====
// ----------------------------------------------------------------------------
// dsdft_pkg
// Shared types, constants and twiddle generation for the damped sliding DFT.
// ----------------------------------------------------------------------------
package dsdft_pkg;

    // default sizing
    localparam int BINS_DEF        = 64;
    localparam int GAIN_DEF        = 32747;
    localparam int QUEUE_DEPTH     = 2;

    // register map, indexed by paddr[2]
    localparam logic [0:0] REG_FIRST_BIN = 1'b0;
    localparam logic [0:0] REG_LAST_BIN  = 1'b1;

    // fixed-point constants for twiddle generation
    localparam longint DAMP_Q30    = 64'sd1073731088;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;

    // bin saturation limits
    localparam logic signed [26:0] BIN_MAX = 27'sd8388607;
    localparam logic signed [26:0] BIN_MIN = -27'sd8388608;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_FETCH = 1'b1
    } op_t;

    // one classified item in the queue
    typedef struct packed {
        op_t                op;
        logic signed [15:0] re;
        logic signed [15:0] im;
    } item_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [5:0] first_bin;
        logic [5:0] last_bin;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_Z,
        ST_UPD,
        ST_DRAIN,
        ST_FRD,
        ST_FSQ,
        ST_FOUT
    } back_state_t;

    // damping by K1 in Q30, rounded half up to Q17, symmetric about zero
    function automatic longint dsdft_damp(input longint v);
        longint a;
        longint rr;
        a  = (v < 0) ? -v : v;
        rr = (a * DAMP_Q30 + (longint'(1) <<< 42)) >>> 43;
        return (v < 0) ? -rr : rr;
    endfunction

    // damped twiddle {re, im}, Q1.17 each, from a 32-bit phase
    function automatic logic [35:0] dsdft_twiddle(input longint ph);
        longint q;
        longint r;
        longint x;
        longint x2, x3, x4, x5, x6, x7, x8, x9;
        longint s, c, sv, cv, re, im;
        logic [17:0] tr;
        logic [17:0] ti;
        q = (ph >>> 30) & 3;
        r = ph & 64'sh3FFF_FFFF;
        if (r <= 64'sh2000_0000)
        begin
            x = (r * HALF_PI_Q30) >>> 30;
        end
        else
        begin
            x = ((64'sh4000_0000 - r) * HALF_PI_Q30) >>> 30;
        end
        x2 = (x * x) >>> 30;
        x3 = (x2 * x) >>> 30;
        x4 = (x2 * x2) >>> 30;
        x5 = (x4 * x) >>> 30;
        x6 = (x4 * x2) >>> 30;
        x7 = (x6 * x) >>> 30;
        x8 = (x4 * x4) >>> 30;
        x9 = (x8 * x) >>> 30;
        s = x - x3 / 6 + x5 / 120 - x7 / 5040 + x9 / 362880;
        c = ONE_Q30 - x2 / 2 + x4 / 24 - x6 / 720 + x8 / 40320;
        if (r <= 64'sh2000_0000)
        begin
            sv = s;
            cv = c;
        end
        else
        begin
            sv = c;
            cv = s;
        end
        case (q)
            0:       begin re = cv;  im = sv;  end
            1:       begin re = -sv; im = cv;  end
            2:       begin re = -cv; im = -sv; end
            default: begin re = sv;  im = -cv; end
        endcase
        tr = 18'(dsdft_damp(re));
        ti = 18'(dsdft_damp(im));
        return {tr, ti};
    endfunction

endpackage

// ===== src/dsdft_front.sv =====
// ----------------------------------------------------------------------------
// dsdft_front
// Input register: accepts items, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module dsdft_front
    import dsdft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic signed [15:0] sample_re,
    input  logic signed [15:0] sample_im,
    output item_t              q_item,
    output logic               q_push,
    input  logic               q_full
);

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t hold_reg;
    item_t hold_next;
    logic  accept;

    // stall only while the held item cannot move on
    assign in_stall = hold_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = hold_valid_reg && !q_full;
    assign q_item   = hold_reg;

    // classify: fetch items carry no sample
    always_comb
    begin
        hold_next = hold_reg;
        if (accept)
        begin
            if (opcode)
            begin
                hold_next.op = OP_FETCH;
                hold_next.re = '0;
                hold_next.im = '0;
            end
            else
            begin
                hold_next.op = OP_PUSH;
                hold_next.re = sample_re;
                hold_next.im = sample_im;
            end
        end
    end

    assign hold_valid_next = (hold_valid_reg && !q_push) || accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

// ===== src/dsdft_queue.sv =====
// ----------------------------------------------------------------------------
// dsdft_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module dsdft_queue
    import dsdft_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/dsdft_back.sv =====
// ----------------------------------------------------------------------------
// dsdft_back
// Execution engine: delay line, pipelined bin update and power readout.
// ----------------------------------------------------------------------------
module dsdft_back
    import dsdft_pkg::*;
#(
    parameter int BINS           = BINS_DEF,
    parameter int DELAY_GAIN_Q15 = GAIN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       q_item,
    input  logic        q_valid,
    output logic        q_pop,
    input  cfg_t        cfg,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  bin_index,
    output logic [47:0] power,
    output logic        last_of_run
);

    localparam int IDX_W = $clog2(BINS);
    localparam int CNT_W = $clog2(BINS + 1);
    localparam logic signed [17:0] GAIN = 18'(DELAY_GAIN_Q15);

    // twiddle rom built at elaboration
    logic [35:0] tw_rom [BINS];
    genvar g;
    generate
        for (g = 0; g < BINS; g++)
        begin : g_tw
            localparam longint PH = ((longint'(g) <<< 32) + BINS / 2) / BINS;
            assign tw_rom[g] = dsdft_twiddle(PH);
        end
    endgenerate

    back_state_t state_reg;
    back_state_t state_next;

    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] k_next;
    logic [IDX_W-1:0] wp_reg;
    logic [IDX_W-1:0] rd_addr;

    logic             hist_we;
    logic             upd_issue;
    logic             sq_load;
    logic             out_load;
    logic             out_free;
    logic             k_last;

    // clamp the range registers to the bin count
    always_comb
    begin
        lo = ({1'b0, cfg.first_bin} > 7'(BINS)) ? CNT_W'(BINS) : CNT_W'(cfg.first_bin);
        hi = ({1'b0, cfg.last_bin}  > 7'(BINS)) ? CNT_W'(BINS) : CNT_W'(cfg.last_bin);
    end

    assign rd_addr  = k_reg[IDX_W-1:0];
    assign k_last   = ((k_reg + 1'b1) == hi);
    assign out_free = !out_valid || !out_stall;

    // ---------------- delay line ----------------
    logic [31:0]        hist_mem [BINS];
    logic [BINS-1:0]    hist_vld_reg;
    logic [31:0]        hist_rd_reg;
    logic               hist_rv_reg;
    logic signed [15:0] s_re_reg;
    logic signed [15:0] s_im_reg;
    logic signed [17:0] z_re_reg;
    logic signed [17:0] z_im_reg;
    logic signed [15:0] h_re;
    logic signed [15:0] h_im;
    logic signed [33:0] d_re_prod;
    logic signed [33:0] d_im_prod;
    logic signed [18:0] d_re;
    logic signed [18:0] d_im;

    // read old sample and store the new one in the same slot
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_rd_reg      <= hist_mem[wp_reg];
            hist_mem[wp_reg] <= {q_item.re, q_item.im};
            s_re_reg         <= q_item.re;
            s_im_reg         <= q_item.im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
            hist_rv_reg  <= 1'b0;
            wp_reg       <= '0;
        end
        else if (hist_we)
        begin
            hist_rv_reg          <= hist_vld_reg[wp_reg];
            hist_vld_reg[wp_reg] <= 1'b1;
            wp_reg <= (wp_reg == IDX_W'(BINS - 1)) ? '0 : wp_reg + 1'b1;
        end
    end

    // comb term z = sample - gain * delayed, rounded half up
    assign h_re      = hist_rv_reg ? $signed(hist_rd_reg[31:16]) : 16'sd0;
    assign h_im      = hist_rv_reg ? $signed(hist_rd_reg[15:0])  : 16'sd0;
    assign d_re_prod = h_re * GAIN + 34'sd16384;
    assign d_im_prod = h_im * GAIN + 34'sd16384;
    assign d_re      = 19'(d_re_prod >>> 15);
    assign d_im      = 19'(d_im_prod >>> 15);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_Z)
        begin
            z_re_reg <= 18'(19'(s_re_reg) - d_re);
            z_im_reg <= 18'(19'(s_im_reg) - d_im);
        end
    end

    // ---------------- bin store, one read and one write port ----------------
    logic [47:0]        bin_mem [BINS];
    logic [BINS-1:0]    bin_vld_reg;
    logic [47:0]        bin_rd_reg;
    logic               bin_rv_reg;
    logic [35:0]        tw1_reg;
    logic [IDX_W-1:0]   idx1_reg;
    logic               v1_reg;
    logic signed [23:0] b_re;
    logic signed [23:0] b_im;

    always_ff @(posedge clk)
    begin
        bin_rd_reg <= bin_mem[rd_addr];
        tw1_reg    <= tw_rom[rd_addr];
        idx1_reg   <= rd_addr;
    end

    assign b_re = bin_rv_reg ? $signed(bin_rd_reg[47:24]) : 24'sd0;
    assign b_im = bin_rv_reg ? $signed(bin_rd_reg[23:0])  : 24'sd0;

    // stage 1: add z, four partial products
    logic signed [24:0] a_re;
    logic signed [24:0] a_im;
    logic signed [17:0] w_re;
    logic signed [17:0] w_im;
    logic signed [42:0] p_rr_reg;
    logic signed [42:0] p_ii_reg;
    logic signed [42:0] p_ri_reg;
    logic signed [42:0] p_ir_reg;
    logic [IDX_W-1:0]   idx2_reg;
    logic               v2_reg;

    assign a_re = 25'(b_re) + 25'(z_re_reg);
    assign a_im = 25'(b_im) + 25'(z_im_reg);
    assign w_re = $signed(tw1_reg[35:18]);
    assign w_im = $signed(tw1_reg[17:0]);

    always_ff @(posedge clk)
    begin
        p_rr_reg <= a_re * w_re;
        p_ii_reg <= a_im * w_im;
        p_ri_reg <= a_re * w_im;
        p_ir_reg <= a_im * w_re;
        idx2_reg <= idx1_reg;
    end

    // stage 2: combine, round, saturate and write back
    logic signed [43:0] sum_re;
    logic signed [43:0] sum_im;
    logic signed [26:0] n_re;
    logic signed [26:0] n_im;
    logic signed [23:0] s24_re;
    logic signed [23:0] s24_im;

    assign sum_re = 44'(p_rr_reg) - 44'(p_ii_reg) + 44'sd65536;
    assign sum_im = 44'(p_ri_reg) + 44'(p_ir_reg) + 44'sd65536;
    assign n_re   = 27'(sum_re >>> 17);
    assign n_im   = 27'(sum_im >>> 17);

    always_comb
    begin
        if (n_re > BIN_MAX)      s24_re = 24'(BIN_MAX);
        else if (n_re < BIN_MIN) s24_re = 24'(BIN_MIN);
        else                     s24_re = n_re[23:0];
        if (n_im > BIN_MAX)      s24_im = 24'(BIN_MAX);
        else if (n_im < BIN_MIN) s24_im = 24'(BIN_MIN);
        else                     s24_im = n_im[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            bin_mem[idx2_reg] <= {s24_re, s24_im};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg <= '0;
            bin_rv_reg  <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end
        else
        begin
            bin_rv_reg <= bin_vld_reg[rd_addr];
            v1_reg     <= upd_issue;
            v2_reg     <= v1_reg;
            if (v2_reg)
            begin
                bin_vld_reg[idx2_reg] <= 1'b1;
            end
        end
    end

    // ---------------- power readout ----------------
    logic [46:0] sq_re_reg;
    logic [46:0] sq_im_reg;
    logic signed [47:0] sq_re;
    logic signed [47:0] sq_im;
    logic        out_valid_reg;
    logic [5:0]  bin_index_reg;
    logic [47:0] power_reg;
    logic        last_reg;

    assign sq_re = b_re * b_re;
    assign sq_im = b_im * b_im;

    always_ff @(posedge clk)
    begin
        if (sq_load)
        begin
            sq_re_reg <= sq_re[46:0];
            sq_im_reg <= sq_im[46:0];
        end
        if (out_load)
        begin
            bin_index_reg <= 6'(k_reg);
            power_reg     <= 48'(sq_re_reg) + 48'(sq_im_reg);
            last_reg      <= k_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bin_index   = bin_index_reg;
    assign power       = power_reg;
    assign last_of_run = last_reg;

    // ---------------- sequencer ----------------
    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.op == OP_PUSH)  state_next = ST_Z;
                    else if (hi != '0)         state_next = ST_FRD;
                end
            end
            ST_Z:     state_next = (lo < hi) ? ST_UPD : ST_IDLE;
            ST_UPD:   state_next = k_last ? ST_DRAIN : ST_UPD;
            ST_DRAIN: state_next = (!v1_reg && !v2_reg) ? ST_IDLE : ST_DRAIN;
            ST_FRD:   state_next = ST_FSQ;
            ST_FSQ:   state_next = ST_FOUT;
            ST_FOUT:
            begin
                if (out_free)
                begin
                    state_next = k_last ? ST_IDLE : ST_FRD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs and bin counter
    always_comb
    begin
        q_pop     = 1'b0;
        hist_we   = 1'b0;
        upd_issue = 1'b0;
        sq_load   = 1'b0;
        out_load  = 1'b0;
        k_next    = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop   = q_valid;
                hist_we = q_valid && (q_item.op == OP_PUSH);
                k_next  = '0;
            end
            ST_Z:
            begin
                k_next = lo;
            end
            ST_UPD:
            begin
                upd_issue = 1'b1;
                k_next    = k_reg + 1'b1;
            end
            ST_FSQ:
            begin
                sq_load = 1'b1;
            end
            ST_FOUT:
            begin
                out_load = out_free;
                if (out_free)
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ===== src/damped_sliding_dft_power.sv =====
// A push runs in the back end as a comb-term step, then bin updates for first_bin up
// to last_bin - 1, one per cycle through the bin store, then a drain of the pipeline.
// A fetch takes its bins one at a time: store read, square, output register.
// Two-entry queue plus input register: up to three items may wait behind a busy engine.
// Reset is asynchronous, active low; bins and delay line read as zero after reset
// through per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// damped_sliding_dft_power
// Damped sliding DFT over BINS complex bins with bin power readout.
// ----------------------------------------------------------------------------
module damped_sliding_dft_power
    import dsdft_pkg::*;
#(
    parameter int BINS           = BINS_DEF,
    parameter int DELAY_GAIN_Q15 = GAIN_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic signed [15:0] sample_re,
    input  logic signed [15:0] sample_im,
    // results
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         bin_index,
    output logic [47:0]        power,
    output logic               last_of_run
);

    logic [5:0] first_bin_reg;
    logic [5:0] last_bin_reg;
    logic       cfg_we;
    cfg_t       cfg;

    item_t      f_item;
    logic       f_push;
    logic       q_full;
    item_t      q_item;
    logic       q_valid;
    logic       q_pop;

    // register writes
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_bin_reg <= '0;
            last_bin_reg  <= 6'(BINS - 1);
        end
        else if (cfg_we)
        begin
            unique case (paddr[2])
                REG_FIRST_BIN: first_bin_reg <= pwdata[5:0];
                REG_LAST_BIN:  last_bin_reg  <= pwdata[5:0];
                default:       first_bin_reg <= first_bin_reg;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (paddr[2])
            REG_FIRST_BIN: prdata = 32'(first_bin_reg);
            REG_LAST_BIN:  prdata = 32'(last_bin_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.first_bin = first_bin_reg;
    assign cfg.last_bin  = last_bin_reg;

    dsdft_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .sample_re (sample_re),
        .sample_im (sample_im),
        .q_item    (f_item),
        .q_push    (f_push),
        .q_full    (q_full)
    );

    dsdft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_item (f_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .not_empty (q_valid)
    );

    dsdft_back #(
        .BINS           (BINS),
        .DELAY_GAIN_Q15 (DELAY_GAIN_Q15)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (q_item),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .cfg         (cfg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bin_index   (bin_index),
        .power       (power),
        .last_of_run (last_of_run)
    );

endmodule

// ===== src/dsdft_checker.sv =====
// ----------------------------------------------------------------------------
// dsdft_checker
// Port-level checks on the result stream of the damped sliding DFT.
// ----------------------------------------------------------------------------
module dsdft_checker
    import dsdft_pkg::*;
#(
    parameter int BINS = BINS_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  bin_index,
    input logic [47:0] power,
    input logic        last_of_run
);

    logic [5:0] last_shadow_reg;
    logic [5:0] exp_idx_reg;
    logic [6:0] hi_eff;
    logic       out_xfer;

    assign out_xfer = out_valid && !out_stall;
    assign hi_eff   = ({1'b0, last_shadow_reg} > 7'(BINS)) ? 7'(BINS)
                                                           : {1'b0, last_shadow_reg};

    // track the last_bin register and the expected run position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_shadow_reg <= 6'(BINS - 1);
            exp_idx_reg     <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && (paddr[2] == REG_LAST_BIN))
            begin
                last_shadow_reg <= pwdata[5:0];
            end
            if (out_xfer)
            begin
                exp_idx_reg <= last_of_run ? 6'd0 : bin_index + 6'd1;
            end
        end
    end

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bin_index) && $stable(power)
                                   && $stable(last_of_run))
        else $error("result changed while stalled");

    // runs count up from bin zero
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> bin_index == exp_idx_reg)
        else $error("bin index out of sequence");

    // results stay inside the fetch range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, bin_index} < hi_eff)
        else $error("bin index beyond last_bin");

    // the run ends on the final bin
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> last_of_run == (({1'b0, bin_index} + 7'd1) == hi_eff))
        else $error("last flag misplaced");

endmodule

bind damped_sliding_dft_power dsdft_checker #(.BINS(BINS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bin_index   (bin_index),
    .power       (power),
    .last_of_run (last_of_run)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the damped sliding DFT with bin power readout:
// pushes complex samples and fetch requests, models the bins in the bench,
// and checks every result in order against the local bin model or a typed-in zero row.
// ----------------------------------------------------------------------------
module tb_top;
    import dsdft_pkg::*;

    localparam int NBINS = 64;
    localparam int GAIN  = 32747;

    typedef struct {
        logic [5:0]  bin;
        logic [47:0] pwr;
        logic        last;
    } bin_power_t;

    typedef struct {
        op_t                op;
        logic signed [15:0] re;
        logic signed [15:0] im;
        bit                 all_zero;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               opcode = 1'b0;
    logic signed [15:0] sample_re = '0;
    logic signed [15:0] sample_im = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [5:0]         bin_index;
    logic [47:0]        power;
    logic               last_of_run;

    damped_sliding_dft_power dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // bench copy of the block state
    longint     hist_re [NBINS];
    longint     hist_im [NBINS];
    longint     acc_re [NBINS];
    longint     acc_im [NBINS];
    longint     rot_re [NBINS];
    longint     rot_im [NBINS];
    int         wr_pos;
    logic [5:0] cur_first = 6'd0;
    logic [5:0] cur_last  = 6'd63;

    bin_power_t pending_powers [$];
    int         errs = 0;
    bit         quiet = 1'b0;
    int         rx_burst = 0;

    // append one expected result to the tail of the queue
    function automatic void queue_power(bin_power_t e);
        pending_powers = {pending_powers, e};
    endfunction

    // Q30 damping, rounded half up to Q17, symmetric about zero
    function automatic longint damp17(longint v);
        longint a;
        a = (v < 0) ? -v : v;
        a = (a * 64'sd1073731088 + (64'sd1 <<< 42)) >>> 43;
        return (v < 0) ? -a : a;
    endfunction

    // damped rotation constants, octant Taylor series in Q30
    task automatic build_rotations();
        longint ph, q, r, x, x2, x3, x4, x5, x6, x7, x8, x9, sn, cs, sv, cv;
        for (int k = 0; k < NBINS; k++)
        begin
            ph = ((longint'(k) <<< 32) + NBINS / 2) / NBINS;
            ph = ph & 64'hFFFF_FFFF;
            q  = (ph >>> 30) & 3;
            r  = ph & 64'h3FFF_FFFF;
            if (r <= 64'h2000_0000)
                x = (r * 64'sd1686629713) >>> 30;
            else
                x = ((64'h4000_0000 - r) * 64'sd1686629713) >>> 30;
            x2 = (x * x) >>> 30;
            x3 = (x2 * x) >>> 30;
            x4 = (x2 * x2) >>> 30;
            x5 = (x4 * x) >>> 30;
            x6 = (x4 * x2) >>> 30;
            x7 = (x6 * x) >>> 30;
            x8 = (x4 * x4) >>> 30;
            x9 = (x8 * x) >>> 30;
            sn = x - x3 / 6 + x5 / 120 - x7 / 5040 + x9 / 362880;
            cs = 64'sd1073741824 - x2 / 2 + x4 / 24 - x6 / 720 + x8 / 40320;
            if (r <= 64'h2000_0000)
            begin
                sv = sn;
                cv = cs;
            end
            else
            begin
                sv = cs;
                cv = sn;
            end
            case (q)
                0:       begin rot_re[k] = damp17(cv);  rot_im[k] = damp17(sv);  end
                1:       begin rot_re[k] = damp17(-sv); rot_im[k] = damp17(cv);  end
                2:       begin rot_re[k] = damp17(-cv); rot_im[k] = damp17(-sv); end
                default: begin rot_re[k] = damp17(sv);  rot_im[k] = damp17(-cv); end
            endcase
        end
    endtask

    function automatic longint sat_bin(longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    // bin update for a pushed sample, or expected powers for a fetch
    task automatic advance_bins(op_t op, logic signed [15:0] re, logic signed [15:0] im);
        longint zr, zi, ar, ai;
        bin_power_t e;
        if (op == OP_PUSH)
        begin
            zr = longint'(re) - ((hist_re[wr_pos] * GAIN + 16384) >>> 15);
            zi = longint'(im) - ((hist_im[wr_pos] * GAIN + 16384) >>> 15);
            hist_re[wr_pos] = re;
            hist_im[wr_pos] = im;
            wr_pos = (wr_pos + 1) % NBINS;
            for (int k = cur_first; k < cur_last; k++)
            begin
                ar = acc_re[k] + zr;
                ai = acc_im[k] + zi;
                acc_re[k] = sat_bin((ar * rot_re[k] - ai * rot_im[k] + 65536) >>> 17);
                acc_im[k] = sat_bin((ar * rot_im[k] + ai * rot_re[k] + 65536) >>> 17);
            end
        end
        else
        begin
            for (int k = 0; k < cur_last; k++)
            begin
                e.bin  = 6'(k);
                e.pwr  = 48'(acc_re[k] * acc_re[k] + acc_im[k] * acc_im[k]);
                e.last = (k + 1 == cur_last);
                queue_power(e);
            end
        end
    endtask

    // register write, setup then access cycle
    task automatic apb_write(logic [0:0] idx, logic [5:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {26'($urandom_range(0, 32'h03FF_FFFF)), val};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FIRST_BIN)
            cur_first = val;
        else
            cur_last = val;
    endtask

    // one input transfer; zero-power rows carry their expectation typed in
    task automatic send_item(op_t op, logic signed [15:0] re, logic signed [15:0] im,
                             bit all_zero);
        bin_power_t e;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        sample_re <= re;
        sample_im <= im;
        do @(posedge clk); while (in_stall);
        if (all_zero)
        begin
            for (int k = 0; k < cur_last; k++)
            begin
                e.bin  = 6'(k);
                e.pwr  = '0;
                e.last = (k + 1 == cur_last);
                queue_power(e);
            end
        end
        else
            advance_bins(op, re, im);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_powers.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (rx_burst > 0)
        begin
            out_stall <= 1'b1;
            rx_burst--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 7) == 0)
                rx_burst = $urandom_range(1, 12);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        bin_power_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_powers.size() == 0)
            begin
                $error("unexpected result transfer: bin_index %0d", bin_index);
                errs++;
            end
            else
            begin
                e = pending_powers.pop_front();
                if (bin_index !== e.bin)
                begin
                    $error("bin_index: expected %0d, got %0d", e.bin, bin_index);
                    errs++;
                end
                if (power !== e.pwr)
                begin
                    $error("power: expected %0d, got %0d", e.pwr, power);
                    errs++;
                end
                if (last_of_run !== e.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", e.last, last_of_run);
                    errs++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #18000000;
        $display("damped_sliding_dft_power regression: fail");
        $finish;
    end

    stim_row_t  dir_rows [] = '{
        '{OP_FETCH, 16'sh0000, 16'sh0000, 1'b1},
        '{OP_PUSH,  16'sh7FFF, 16'sh7FFF, 1'b0},
        '{OP_PUSH,  16'sh8000, 16'sh8000, 1'b0},
        '{OP_PUSH,  16'sh7FFF, 16'sh8000, 1'b0},
        '{OP_PUSH,  16'sh8000, 16'sh7FFF, 1'b0},
        '{OP_PUSH,  16'sh0000, 16'sh0000, 1'b0},
        '{OP_PUSH,  16'sh0001, 16'shFFFF, 1'b0},
        '{OP_FETCH, 16'sh7FFF, 16'sh8000, 1'b0},
        '{OP_PUSH,  16'sh7FFF, 16'sh7FFF, 1'b0},
        '{OP_PUSH,  16'sh7FFF, 16'sh7FFF, 1'b0},
        '{OP_PUSH,  16'sh7FFF, 16'sh7FFF, 1'b0},
        '{OP_PUSH,  16'sh7FFF, 16'sh7FFF, 1'b0},
        '{OP_PUSH,  16'sh8000, 16'sh7FFF, 1'b0},
        '{OP_FETCH, 16'sh0000, 16'shFFFF, 1'b0},
        '{OP_PUSH,  16'sh5555, 16'shAAAA, 1'b0},
        '{OP_FETCH, 16'sh0000, 16'sh0000, 1'b0}
    };
    logic [5:0] ph_first [8] = '{6'd0, 6'd0, 6'd63, 6'd40, 6'd5, 6'd0, 6'd17, 6'd0};
    logic [5:0] ph_last  [8] = '{6'd63, 6'd0, 6'd63, 6'd10, 6'd40, 6'd1, 6'd63, 6'd63};

    // stimulus
    initial
    begin
        op_t op;
        for (int k = 0; k < NBINS; k++)
        begin
            hist_re[k] = 0;
            hist_im[k] = 0;
            acc_re[k]  = 0;
            acc_im[k]  = 0;
        end
        wr_pos = 0;
        build_rotations();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].re, dir_rows[i].im, dir_rows[i].all_zero);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            apb_write(REG_FIRST_BIN, ph_first[p]);
            apb_write(REG_LAST_BIN, ph_last[p]);
            quiet = (p == 7);
            repeat (56)
            begin
                op = ($urandom_range(0, 99) < 12) ? OP_FETCH : OP_PUSH;
                if ($urandom_range(0, 9) == 0)
                    send_item(op, $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                              $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000, 1'b0);
                else
                    send_item(op, 16'($urandom), 16'($urandom), 1'b0);
            end
            send_item(OP_FETCH, 16'($urandom), 16'($urandom), 1'b0);
            drain();
        end

        if (errs == 0)
            $display("damped_sliding_dft_power regression: pass");
        else
            $display("damped_sliding_dft_power regression: fail");
        $finish;
    end

endmodule
